@@ src/ncs_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the nested comment stripper
// no dependencies; imported by ncs_out_stage and nested_comment_stripper
package ncs_pkg;

   localparam int MAX_INDENT    = 16;
   localparam int PENDING_DEPTH = 32;
   localparam int LINE_LENGTH   = 4096;
   localparam int MAX_NEST      = 255;

   localparam int IND_AW  = $clog2(MAX_INDENT);
   localparam int PEND_AW = $clog2(PENDING_DEPTH);
   localparam int IND_CW  = $clog2(MAX_INDENT + 1);
   localparam int PEND_CW = $clog2(PENDING_DEPTH + 1);
   localparam int IDX_W   = (IND_CW > PEND_CW) ? IND_CW : PEND_CW;
   localparam int COL_CW  = $clog2(LINE_LENGTH + 1);

   // request codes
   localparam logic [1:0] REQ_BYTE = 2'd0;
   localparam logic [1:0] REQ_EOL  = 2'd1;
   localparam logic [1:0] REQ_EOF  = 2'd2;

   // result kinds
   localparam logic [2:0] KIND_BYTE     = 3'd0;
   localparam logic [2:0] KIND_LINE_END = 3'd1;
   localparam logic [2:0] KIND_INDENT   = 3'd2;
   localparam logic [2:0] KIND_MISMATCH = 3'd3;
   localparam logic [2:0] KIND_INVALID  = 3'd4;
   localparam logic [2:0] KIND_UNTERM   = 3'd5;

   // held whitespace codes
   localparam logic [1:0] WS_SPACE  = 2'd0;
   localparam logic [1:0] WS_TAB    = 2'd1;
   localparam logic [1:0] WS_CLOSED = 2'd2;

   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_STAR  = 8'h2A;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  kept_byte;
      logic        has_column;
      logic [11:0] column;
      logic [11:0] span_end;
      logic [31:0] line_number;
      logic        line_valid;
      logic        overflow;
   } ncs_result_type;

   typedef struct packed {
      logic           emit;
      logic           finish;
      ncs_result_type res;
   } ncs_ctl_type;

   typedef struct packed {
      logic can_emit;
      logic finish_done;
   } ncs_stat_type;

   // utf-8 pitch of a lead byte, zero when invalid
   function automatic logic [2:0] pitch_of(input logic [7:0] b);
      logic [2:0] p;
      p = 3'd0;
      if (b < 8'h80) p = 3'd1;
      else if (b >= 8'hC0 && b <= 8'hDF) p = 3'd2;
      else if (b >= 8'hE0 && b <= 8'hEF) p = 3'd3;
      else if (b >= 8'hF0 && b <= 8'hF7) p = 3'd4;
      return p;
   endfunction

   // exclusive span end of a two-byte mark, saturating
   function automatic logic [11:0] span2(input logic [11:0] col);
      return (col >= 12'hFFE) ? 12'hFFF : col + 12'd2;
   endfunction

endpackage

@@ src/nested_comment_stripper.sv @@
`timescale 1ns / 1ps
// nested comment stripper: one item at a time through a sequencer.
// a kept byte first flushes the indents as tabs (at a line start only) and then the held
// whitespace, one result per entry; a lone held slash or star adds its own flush. The
// last result of an item is marked on the output, and no new item is taken until the
// sequencer is back in idle.
// reset: synchronous, active high; counts clear at once, no clearing pass.
// depends on ncs_pkg and ncs_out_stage
module nested_comment_stripper import ncs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,  // source_byte
   input  logic [1:0]   req_tuser,  // req_type
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [71:0]  rsp_tdata,  // kept_byte, has_column, column, span_end,
                                    // line_number, line_valid, overflow, zero pad
   output logic [2:0]   rsp_tuser,  // result_kind
   output logic         rsp_tlast,
   input  logic         csr_we,
   input  logic [31:0]  csr_wdata
);

   typedef enum logic [10:0] {
      ST_IDLE    = 11'b00000000001,
      ST_DECODE  = 11'b00000000010,
      ST_HELD    = 11'b00000000100,
      ST_MAIN    = 11'b00000001000,
      ST_LINEEND = 11'b00000010000,
      ST_EOFTAIL = 11'b00000100000,
      ST_CWARN   = 11'b00001000000,
      ST_CIND    = 11'b00010000000,
      ST_CPEND   = 11'b00100000000,
      ST_CBYTE   = 11'b01000000000,
      ST_FINISH  = 11'b10000000000
   } state_type;

   state_type          state_ff, state_in, ret_ff, ret_in;
   logic [1:0]         it_type_ff, it_type_in;
   logic [7:0]         it_byte_ff, it_byte_in;
   logic [11:0]        cur_col_ff, cur_col_in;
   logic [7:0]         tgt_byte_ff, tgt_byte_in;
   logic [11:0]        tgt_col_ff, tgt_col_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;

   logic [7:0]         nest_ff, nest_in;
   logic               lc_ff, lc_in;
   logic               bnd_ff, bnd_in;
   logic               iph_ff, iph_in;
   logic [1:0]         run_ff, run_in;
   logic               xv_ff, xv_in;
   logic [11:0]        xcol_ff, xcol_in;
   logic [IND_CW-1:0]  ind_cnt_ff, ind_cnt_in;
   logic [PEND_CW-1:0] pend_cnt_ff, pend_cnt_in;
   logic               hv_ff, hv_in;
   logic [7:0]         hb_ff, hb_in;
   logic [11:0]        hcol_ff, hcol_in;
   logic [COL_CW-1:0]  colc_ff, colc_in;
   logic [1:0]         utf_ff, utf_in;
   logic [31:0]        line_ff, line_in;
   logic [31:0]        first_ff, first_in;
   logic [31:0]        oline_ff, oline_in;
   logic [11:0]        ocol_ff, ocol_in;
   logic               abort_ff, abort_in;
   logic               ovf_ff, ovf_in;

   // indent column and held whitespace memories
   logic [11:0]        ind_mem [MAX_INDENT];
   logic [13:0]        pend_mem [PENDING_DEPTH];
   logic               ind_we, pend_we;
   logic [IND_AW-1:0]  ind_waddr, ind_raddr;
   logic [PEND_AW-1:0] pend_waddr, pend_raddr;
   logic [11:0]        ind_wdata, ind_rdata_ff;
   logic [13:0]        pend_wdata, pend_rdata_ff;

   ncs_ctl_type        ctl;
   ncs_stat_type       stat;
   logic               emit_fire;
   logic               do_clear, do_restart;
   logic [11:0]        c;
   logic [2:0]         p;
   logic               accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign emit_fire  = ctl.emit && stat.can_emit;

   always_ff @(posedge clock) begin
      if (ind_we) ind_mem[ind_waddr] <= ind_wdata;
      if (pend_we) pend_mem[pend_waddr] <= pend_wdata;
      ind_rdata_ff  <= ind_mem[ind_raddr];
      pend_rdata_ff <= pend_mem[pend_raddr];
   end

   // sequencer and state update
   always_comb begin
      state_in = state_ff;     ret_in = ret_ff;
      it_type_in = it_type_ff; it_byte_in = it_byte_ff;
      cur_col_in = cur_col_ff; tgt_byte_in = tgt_byte_ff; tgt_col_in = tgt_col_ff;
      idx_in = idx_ff;
      nest_in = nest_ff; lc_in = lc_ff; bnd_in = bnd_ff; iph_in = iph_ff;
      run_in = run_ff; xv_in = xv_ff; xcol_in = xcol_ff;
      ind_cnt_in = ind_cnt_ff; pend_cnt_in = pend_cnt_ff;
      hv_in = hv_ff; hb_in = hb_ff; hcol_in = hcol_ff;
      colc_in = colc_ff; utf_in = utf_ff; line_in = line_ff; first_in = first_ff;
      oline_in = oline_ff; ocol_in = ocol_ff; abort_in = abort_ff; ovf_in = ovf_ff;
      ind_we = 1'b0; ind_waddr = ind_cnt_ff[IND_AW-1:0]; ind_wdata = '0;
      pend_we = 1'b0; pend_waddr = pend_cnt_ff[PEND_AW-1:0]; pend_wdata = '0;
      ind_raddr = '0; pend_raddr = '0;
      ctl = '0;
      ctl.res.line_number = line_ff;
      ctl.res.overflow = ovf_ff;
      do_clear = 1'b0; do_restart = 1'b0;
      c = '0;
      p = pitch_of(it_byte_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               it_type_in = req_tuser;
               it_byte_in = req_tdata;
               state_in   = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_FINISH;
            if (abort_ff) begin
               if (it_type_ff == REQ_EOF) do_restart = 1'b1;
            end else if (it_type_ff == REQ_BYTE) begin
               // take a column, saturating at one below the line length
               if (colc_ff >= COL_CW'(LINE_LENGTH)) begin
                  ovf_in = 1'b1;
                  c = 12'(LINE_LENGTH - 1);
               end else begin
                  c = colc_ff[11:0];
                  colc_in = colc_ff + 1'b1;
               end
               cur_col_in = c;
               if (utf_ff != 2'd0) begin
                  // continuation byte
                  utf_in = utf_ff - 2'd1;
                  if (nest_ff == 8'd0 && !lc_ff) begin
                     tgt_byte_in = it_byte_ff;
                     tgt_col_in  = c;
                     ret_in      = ST_FINISH;
                     state_in    = ST_CBYTE;
                  end
               end else if (iph_ff && it_byte_ff == CH_SPACE) begin
                  // four spaces make one indent
                  if (run_ff == 2'd3) begin
                     run_in = 2'd0;
                     if (ind_cnt_ff < IND_CW'(MAX_INDENT)) begin
                        ind_we = 1'b1;
                        ind_wdata = c - 12'd3;
                        ind_cnt_in = ind_cnt_ff + 1'b1;
                     end else ovf_in = 1'b1;
                  end else run_in = run_ff + 2'd1;
               end else begin
                  if (iph_ff) begin
                     if (run_ff != 2'd0 && !xv_ff) begin
                        xv_in = 1'b1;
                        xcol_in = c - 12'(run_ff);
                     end
                     run_in = 2'd0;
                  end
                  if (iph_ff && it_byte_ff == CH_TAB) begin
                     if (ind_cnt_ff < IND_CW'(MAX_INDENT)) begin
                        ind_we = 1'b1;
                        ind_wdata = c;
                        ind_cnt_in = ind_cnt_ff + 1'b1;
                     end else ovf_in = 1'b1;
                  end else begin
                     iph_in = 1'b0;
                     state_in = hv_ff ? ST_HELD : ST_MAIN;
                  end
               end
            end else if (it_type_ff == REQ_EOL) begin
               state_in = hv_ff ? ST_HELD : ST_LINEEND;
            end else if (it_type_ff == REQ_EOF) begin
               if (colc_ff != '0 || hv_ff) state_in = hv_ff ? ST_HELD : ST_LINEEND;
               else state_in = ST_EOFTAIL;
            end
         end
         ST_HELD: begin
            // resolve the held slash or star
            hv_in = 1'b0;
            if (it_type_ff == REQ_BYTE && hb_ff == CH_SLASH && it_byte_ff == CH_STAR) begin
               if (nest_ff == 8'd0) begin
                  oline_in = line_ff;
                  ocol_in  = hcol_ff;
               end
               if (nest_ff < 8'(MAX_NEST)) nest_in = nest_ff + 8'd1;
               else ovf_in = 1'b1;
               state_in = ST_FINISH;
            end else if (it_type_ff == REQ_BYTE && hb_ff == CH_STAR
                         && it_byte_ff == CH_SLASH) begin
               if (nest_ff == 8'd0) begin
                  ctl.emit = 1'b1;
                  ctl.res.kind = KIND_MISMATCH;
                  ctl.res.has_column = 1'b1;
                  ctl.res.column = hcol_ff;
                  ctl.res.span_end = span2(hcol_ff);
                  hv_in = hv_ff;
                  if (emit_fire) begin
                     hv_in = 1'b0;
                     abort_in = 1'b1;
                     state_in = ST_FINISH;
                  end
               end else begin
                  nest_in = nest_ff - 8'd1;
                  if (nest_ff == 8'd1 && !bnd_ff) begin
                     if (pend_cnt_ff < PEND_CW'(PENDING_DEPTH)) begin
                        pend_we = 1'b1;
                        pend_wdata = {WS_CLOSED, 12'd0};
                        pend_cnt_in = pend_cnt_ff + 1'b1;
                     end else ovf_in = 1'b1;
                  end
                  state_in = ST_FINISH;
               end
            end else if (it_type_ff == REQ_BYTE && hb_ff == CH_SLASH
                         && it_byte_ff == CH_SLASH) begin
               if (nest_ff == 8'd0) lc_in = 1'b1;
               state_in = ST_FINISH;
            end else begin
               // lone slash or star: always a one-byte character
               utf_in = 2'd0;
               ret_in = (it_type_ff == REQ_BYTE) ? ST_MAIN : ST_LINEEND;
               if (nest_ff == 8'd0 && !lc_ff) begin
                  tgt_byte_in = hb_ff;
                  tgt_col_in = hcol_ff;
                  state_in = ST_CWARN;
               end else begin
                  state_in = (it_type_ff == REQ_BYTE) ? ST_MAIN : ST_LINEEND;
               end
            end
         end
         ST_MAIN: begin
            state_in = ST_FINISH;
            if (it_byte_ff == CH_SLASH || it_byte_ff == CH_STAR) begin
               hv_in = 1'b1;
               hb_in = it_byte_ff;
               hcol_in = cur_col_ff;
            end else if (p == 3'd0) begin
               ctl.emit = 1'b1;
               ctl.res.kind = KIND_INVALID;
               if (emit_fire) abort_in = 1'b1;
               else state_in = ST_MAIN;
            end else begin
               utf_in = 2'(p - 3'd1);
               if (nest_ff == 8'd0 && !lc_ff) begin
                  if (it_byte_ff == CH_SPACE || it_byte_ff == CH_TAB) begin
                     if (!bnd_ff) begin
                        if (pend_cnt_ff < PEND_CW'(PENDING_DEPTH)) begin
                           pend_we = 1'b1;
                           pend_wdata = {(it_byte_ff == CH_TAB) ? WS_TAB : WS_SPACE,
                                         cur_col_ff};
                           pend_cnt_in = pend_cnt_ff + 1'b1;
                        end else ovf_in = 1'b1;
                     end
                  end else begin
                     tgt_byte_in = it_byte_ff;
                     tgt_col_in = cur_col_ff;
                     ret_in = ST_FINISH;
                     state_in = ST_CWARN;
                  end
               end
            end
         end
         ST_LINEEND: begin
            ctl.emit = 1'b1;
            ctl.res.kind = KIND_LINE_END;
            ctl.res.line_valid = !bnd_ff;
            if (emit_fire) begin
               line_in = line_ff + 32'd1;
               do_clear = 1'b1;
               state_in = (it_type_ff == REQ_EOF) ? ST_EOFTAIL : ST_FINISH;
            end
         end
         ST_EOFTAIL: begin
            if (nest_ff != 8'd0) begin
               ctl.emit = 1'b1;
               ctl.res.kind = KIND_UNTERM;
               ctl.res.has_column = 1'b1;
               ctl.res.column = ocol_ff;
               ctl.res.span_end = span2(ocol_ff);
               ctl.res.line_number = oline_ff;
            end
            if (nest_ff == 8'd0 || emit_fire) begin
               do_restart = 1'b1;
               state_in = ST_FINISH;
            end
         end
         ST_CWARN: begin
            // first real content of the line: warning for stray spaces
            if (bnd_ff && xv_ff) begin
               ctl.emit = 1'b1;
               ctl.res.kind = KIND_INDENT;
               ctl.res.has_column = 1'b1;
               ctl.res.column = xcol_ff;
               ctl.res.span_end = tgt_col_ff;
            end
            idx_in = '0;
            if (!(bnd_ff && xv_ff) || emit_fire) begin
               xv_in = 1'b0;
               if (bnd_ff) begin
                  bnd_in = 1'b0;
                  state_in = ST_CIND;
               end else state_in = ST_CPEND;
            end
         end
         ST_CIND: begin
            // flush indents as tabs
            ind_raddr = idx_ff[IND_AW-1:0];
            if (idx_ff < IDX_W'(ind_cnt_ff)) begin
               ctl.emit = 1'b1;
               ctl.res.kind = KIND_BYTE;
               ctl.res.kept_byte = CH_TAB;
               ctl.res.has_column = 1'b1;
               ctl.res.column = ind_rdata_ff;
               if (emit_fire) begin
                  idx_in = idx_ff + 1'b1;
                  ind_raddr = idx_in[IND_AW-1:0];
               end
            end else begin
               ind_cnt_in = '0;
               idx_in = '0;
               state_in = ST_CPEND;
            end
         end
         ST_CPEND: begin
            // flush held whitespace
            pend_raddr = idx_ff[PEND_AW-1:0];
            if (idx_ff < IDX_W'(pend_cnt_ff)) begin
               ctl.emit = 1'b1;
               ctl.res.kind = KIND_BYTE;
               if (pend_rdata_ff[13:12] == WS_CLOSED) begin
                  ctl.res.kept_byte = CH_SPACE;
               end else begin
                  ctl.res.kept_byte = (pend_rdata_ff[13:12] == WS_TAB) ? CH_TAB : CH_SPACE;
                  ctl.res.has_column = 1'b1;
                  ctl.res.column = pend_rdata_ff[11:0];
               end
               if (emit_fire) begin
                  idx_in = idx_ff + 1'b1;
                  pend_raddr = idx_in[PEND_AW-1:0];
               end
            end else begin
               pend_cnt_in = '0;
               state_in = ST_CBYTE;
            end
         end
         ST_CBYTE: begin
            ctl.emit = 1'b1;
            ctl.res.kind = KIND_BYTE;
            ctl.res.kept_byte = tgt_byte_ff;
            ctl.res.has_column = 1'b1;
            ctl.res.column = tgt_col_ff;
            if (emit_fire) state_in = ret_ff;
         end
         ST_FINISH: begin
            ctl.finish = 1'b1;
            if (stat.finish_done) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase

      // per-line and per-file clearing
      if (do_clear || do_restart) begin
         lc_in = 1'b0; bnd_in = 1'b1; iph_in = 1'b1; run_in = 2'd0;
         xv_in = 1'b0; xcol_in = '0; ind_cnt_in = '0; pend_cnt_in = '0;
         hv_in = 1'b0; hb_in = '0; hcol_in = '0; colc_in = '0; utf_in = 2'd0;
      end
      if (do_restart) begin
         nest_in = '0; line_in = first_ff; oline_in = '0; ocol_in = '0;
         abort_in = 1'b0; ovf_in = 1'b0;
      end
      if (csr_we) begin
         first_in = csr_wdata;
         line_in  = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; ret_ff <= ST_FINISH; idx_ff <= '0;
         nest_ff <= '0; lc_ff <= 1'b0; bnd_ff <= 1'b1; iph_ff <= 1'b1;
         run_ff <= 2'd0; xv_ff <= 1'b0; xcol_ff <= '0;
         ind_cnt_ff <= '0; pend_cnt_ff <= '0;
         hv_ff <= 1'b0; hb_ff <= '0; hcol_ff <= '0;
         colc_ff <= '0; utf_ff <= 2'd0; line_ff <= 32'd1; first_ff <= 32'd1;
         oline_ff <= '0; ocol_ff <= '0; abort_ff <= 1'b0; ovf_ff <= 1'b0;
      end else begin
         state_ff <= state_in; ret_ff <= ret_in; idx_ff <= idx_in;
         nest_ff <= nest_in; lc_ff <= lc_in; bnd_ff <= bnd_in; iph_ff <= iph_in;
         run_ff <= run_in; xv_ff <= xv_in; xcol_ff <= xcol_in;
         ind_cnt_ff <= ind_cnt_in; pend_cnt_ff <= pend_cnt_in;
         hv_ff <= hv_in; hb_ff <= hb_in; hcol_ff <= hcol_in;
         colc_ff <= colc_in; utf_ff <= utf_in; line_ff <= line_in; first_ff <= first_in;
         oline_ff <= oline_in; ocol_ff <= ocol_in; abort_ff <= abort_in; ovf_ff <= ovf_in;
      end
      it_type_ff <= it_type_in; it_byte_ff <= it_byte_in; cur_col_ff <= cur_col_in;
      tgt_byte_ff <= tgt_byte_in; tgt_col_ff <= tgt_col_in;
   end

   ncs_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // counts stay within their stores
   a_ind_cnt: assert property (@(posedge clock) disable iff (reset)
      ind_cnt_ff <= IND_CW'(MAX_INDENT)) else $error("indent count beyond depth");
   a_pend_cnt: assert property (@(posedge clock) disable iff (reset)
      pend_cnt_ff <= PEND_CW'(PENDING_DEPTH)) else $error("whitespace count beyond depth");
   // an aborted file gives no results
   a_abort_quiet: assert property (@(posedge clock) disable iff (reset)
      abort_ff |-> !ctl.emit) else $error("result while aborted");
   // the sequencer returns to idle once an item is finished
   a_finish_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && stat.finish_done) |=> req_tready)
      else $error("sequencer did not return to idle");

endmodule

@@ src/ncs_out_stage.sv @@
`timescale 1ns / 1ps
// output stage: holds the newest result back one step so the last one of an item
// can be marked, and an output register toward the result channel; uses ncs_pkg
module ncs_out_stage import ncs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  ncs_ctl_type  ctl,
   output ncs_stat_type stat,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [71:0]  rsp_tdata,  // kept_byte, has_column, column, span_end,
                                    // line_number, line_valid, overflow, zero pad
   output logic [2:0]   rsp_tuser,  // result_kind
   output logic         rsp_tlast
);

   logic           out_valid_ff, out_valid_in;
   logic           out_last_ff, out_last_in;
   ncs_result_type out_data_ff, out_data_in;
   logic           hold_valid_ff, hold_valid_in;
   ncs_result_type hold_data_ff, hold_data_in;
   logic           out_free;
   logic           can_emit;

   assign out_free = !out_valid_ff || rsp_tready;
   assign can_emit = !hold_valid_ff || out_free;
   assign stat     = '{can_emit: can_emit, finish_done: ctl.finish && can_emit};

   // move held result forward on a new one, or mark it last at item end
   always_comb begin
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_last_in   = out_last_ff;
      out_data_in   = out_data_ff;
      hold_valid_in = hold_valid_ff;
      hold_data_in  = hold_data_ff;
      if (ctl.emit && can_emit) begin
         if (hold_valid_ff) begin
            out_valid_in = 1'b1;
            out_last_in  = 1'b0;
            out_data_in  = hold_data_ff;
         end
         hold_valid_in = 1'b1;
         hold_data_in  = ctl.res;
      end else if (ctl.finish && hold_valid_ff && out_free) begin
         out_valid_in  = 1'b1;
         out_last_in   = 1'b1;
         out_data_in   = hold_data_ff;
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         hold_valid_ff <= hold_valid_in;
      end
      out_last_ff  <= out_last_in;
      out_data_ff  <= out_data_in;
      hold_data_ff <= hold_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_data_ff.kind;
   assign rsp_tdata  = {5'd0, out_data_ff.overflow, out_data_ff.line_valid,
                        out_data_ff.line_number, out_data_ff.span_end,
                        out_data_ff.column, out_data_ff.has_column,
                        out_data_ff.kept_byte};

endmodule
